// ----- hdl/fnes_pkg.sv -----
package fnes_pkg;

  // parameter defaults
  localparam int SlotCountDef = 65536;
  localparam int EntityMaxDef = 16384;
  localparam int RelationMax  = 4096;

  // field widths
  localparam int KindW   = 2;
  localparam int SlotW   = 16;
  localparam int RelW    = 12;
  localparam int EntW    = 14;
  localparam int RangeW  = 17;
  localparam int DrawW   = 64;
  localparam int CountW  = 15;
  localparam int EntryW  = RelW + EntW;
  localparam int RangeEW = 2 * RangeW;
  localparam int InDataW = 144;
  localparam int InUserW = 3;
  localparam int OutDataW = 16;

  // signed width for slot indices and index arithmetic
  localparam int IdxW = 20;

  localparam logic [CountW-1:0] EntityCountRst = 15'd16384;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD_ENTRY = 2'd0,
    KIND_LOAD_RANGE = 2'd1,
    KIND_SAMPLE     = 2'd2,
    KIND_NONE       = 2'd3
  } kind_e;

endpackage

// ----- hdl/fnes_ram.sv -----
module fnes_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/filtered_negative_entity_sampler.sv -----
// channel  | signals           | tdata fields (low bit up)                    | tuser
// ---------+-------------------+----------------------------------------------+-------------
// s_axis   | tvalid/tready     | slot, relation, entity, range_first,         | kind, side
//          |                   | range_last, draw                             |
// m_axis   | tvalid/tready     | replacement_entity                           | no_candidate
// cfg      | cfg_we_i          | entity_count                                 | -
//
// loads are written when accepted and the sampler stays ready; a sample's result moves to the
// output register once finished and the register is free, then the next request is taken: each
// search step is a registered read of the table memory followed by an update,
// and the modulo retires one draw bit a cycle
// reset clears control and sets entity_count to 16384; memories hold garbage until loaded
// a finished result waits in the output register; a new request is taken meanwhile, and
// the next result waits in its final state while the output is stalled
module filtered_negative_entity_sampler
  import fnes_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDef,
  parameter int ENTITY_MAX = EntityMaxDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CountW-1:0]    cfg_wdata_i,    // entity_count
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // slot, relation, entity, range_first,
                                               // range_last, draw, zero pad
  input  logic [InUserW-1:0]   s_axis_tuser,   // kind, side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,   // replacement_entity, zero pad
  output logic                 m_axis_tuser    // no_candidate
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int EW  = $clog2(ENTITY_MAX);
  localparam int TAW = SW + 1;
  localparam int RAW = EW + 1;

  typedef enum logic [16:0] {
    ST_IDLE    = 17'b1 << 0,
    ST_RNG     = 17'b1 << 1,
    ST_L_STEP  = 17'b1 << 2,
    ST_L_WAIT  = 17'b1 << 3,
    ST_R_STEP  = 17'b1 << 4,
    ST_R_WAIT  = 17'b1 << 5,
    ST_CHK_LL  = 17'b1 << 6,
    ST_CHK_RR  = 17'b1 << 7,
    ST_CHK_END = 17'b1 << 8,
    ST_MOD     = 17'b1 << 9,
    ST_P_LL    = 17'b1 << 10,
    ST_P_RR    = 17'b1 << 11,
    ST_P_END   = 17'b1 << 12,
    ST_B_STEP  = 17'b1 << 13,
    ST_B_WAIT  = 17'b1 << 14,
    ST_FIN     = 17'b1 << 15,
    ST_SPARE   = 17'b1 << 16
  } state_e;

  typedef logic signed [IdxW-1:0] idx_t;

  // request fields
  kind_e              in_kind;
  logic               in_side;
  logic [SlotW-1:0]   in_slot;
  logic [RelW-1:0]    in_rel;
  logic [EntW-1:0]    in_ent;
  logic [RangeW-1:0]  in_first;
  logic [RangeW-1:0]  in_last;
  logic [DrawW-1:0]   in_draw;

  assign in_kind  = kind_e'(s_axis_tuser[1:0]);
  assign in_side  = s_axis_tuser[2];
  assign in_slot  = s_axis_tdata[15:0];
  assign in_rel   = s_axis_tdata[27:16];
  assign in_ent   = s_axis_tdata[41:28];
  assign in_first = s_axis_tdata[58:42];
  assign in_last  = s_axis_tdata[75:59];
  assign in_draw  = s_axis_tdata[139:76];

  state_e              state_q, state_d;
  logic [CountW-1:0]   ecount_q;
  logic                side_q;
  logic [RelW-1:0]     rel_q;
  logic [DrawW-1:0]    draw_q;
  idx_t                first_q, last_q, lo_q, hi_q, mid_q, ll_q, rr_q, len_q;
  logic [CountW-1:0]   div_q, rem_q;
  logic [5:0]          bit_q;
  logic                ok_q;
  logic [EntW-1:0]     par_ll_q;
  logic [EntW-1:0]     res_q;
  logic                noc_q;
  logic                out_valid_q;
  logic [EntW-1:0]     out_ent_q;
  logic                out_noc_q;

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // range checks on the request
  logic slot_ok, ent_ok, rel_ok;
  logic [31:0] slot_w, ent_w;
  assign slot_w  = 32'(in_slot);
  assign ent_w   = 32'(in_ent);
  assign slot_ok = slot_w < 32'(SLOT_COUNT);
  assign ent_ok  = ent_w < 32'(ENTITY_MAX);
  assign rel_ok  = 32'(in_rel) < 32'(RelationMax);

  // table memory: both sides, side bit on top of the address
  logic             tab_we;
  logic [TAW-1:0]   tab_waddr, tab_raddr;
  logic [EntryW-1:0] tab_rdata;
  logic [RelW-1:0]  rd_rel;
  logic [EntW-1:0]  rd_par;

  assign tab_we    = accept && (in_kind == KIND_LOAD_ENTRY) && slot_ok && ent_ok && rel_ok;
  assign tab_waddr = {in_side, slot_w[SW-1:0]};
  assign rd_rel    = tab_rdata[EntryW-1:EntW];
  assign rd_par    = tab_rdata[EntW-1:0];

  fnes_ram #(
    .Width (EntryW),
    .Depth (2 ** TAW)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i ({in_rel, in_ent}),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // range memory: first in the low half, last in the high half
  logic              rng_we;
  logic [RAW-1:0]    rng_addr;
  logic [RangeEW-1:0] rng_rdata;

  assign rng_we   = accept && (in_kind == KIND_LOAD_RANGE) && ent_ok;
  assign rng_addr = {in_side, ent_w[EW-1:0]};

  fnes_ram #(
    .Width (RangeEW),
    .Depth (2 ** RAW)
  ) u_rng_ram (
    .clk_i   (clk_i),
    .we_i    (rng_we),
    .waddr_i (rng_addr),
    .wdata_i ({in_last, in_first}),
    .raddr_i (rng_addr),
    .rdata_o (rng_rdata)
  );

  // search midpoint and table read address
  idx_t mid_c, rd_idx;
  logic more_c;
  logic [IdxW-1:0] rd_idx_u;
  assign mid_c  = (lo_q + hi_q) >>> 1;
  assign more_c = (lo_q + idx_t'(1)) < hi_q;

  always_comb begin
    case (state_q)
      ST_CHK_LL, ST_P_LL: rd_idx = ll_q;
      ST_CHK_RR, ST_P_RR: rd_idx = rr_q;
      default:            rd_idx = mid_c;
    endcase
  end
  assign rd_idx_u  = $unsigned(rd_idx);
  assign tab_raddr = {side_q, SW'(rd_idx_u)};

  // decoded range
  idx_t rng_first, rng_last_raw, rng_last;
  assign rng_first    = idx_t'(rng_rdata[RangeW-1:0]);
  assign rng_last_raw = idx_t'($signed(rng_rdata[RangeEW-1:RangeW]));
  assign rng_last     = (int'(rng_last_raw) > SLOT_COUNT - 1) ? idx_t'(SLOT_COUNT - 1)
                                                               : rng_last_raw;

  // entity count limit and divisor
  idx_t count_c, len_c, divisor_c;
  assign count_c   = (32'(ecount_q) > 32'(ENTITY_MAX)) ? idx_t'(ENTITY_MAX)
                                                        : idx_t'(ecount_q);
  assign len_c     = rr_q - ll_q + idx_t'(1);
  assign divisor_c = count_c - len_c;

  // one restoring step of the modulo
  logic [CountW:0] trial, rem_n;
  assign trial = {rem_q, draw_q[DrawW-1]};
  assign rem_n = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;

  // replacement arithmetic
  idx_t pick_s, gap_rr, gap_mid;
  assign pick_s  = idx_t'(rem_q);
  assign gap_rr  = idx_t'(rd_par) - rr_q + ll_q - idx_t'(1);
  assign gap_mid = idx_t'(rd_par) - mid_q + ll_q - idx_t'(1);

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_kind == KIND_SAMPLE) begin
          state_d = (ent_ok && rel_ok) ? ST_RNG : ST_FIN;
        end
      end
      ST_RNG:     state_d = (rng_first > rng_last) ? ST_FIN : ST_L_STEP;
      ST_L_STEP:  state_d = more_c ? ST_L_WAIT : ST_R_STEP;
      ST_L_WAIT:  state_d = ST_L_STEP;
      ST_R_STEP: begin
        if (more_c) begin
          state_d = ST_R_WAIT;
        end else begin
          state_d = (ll_q > lo_q) ? ST_FIN : ST_CHK_LL;
        end
      end
      ST_R_WAIT:  state_d = ST_R_STEP;
      ST_CHK_LL:  state_d = ST_CHK_RR;
      ST_CHK_RR:  state_d = ST_CHK_END;
      ST_CHK_END: begin
        if (!ok_q || rd_rel != rel_q || divisor_c <= idx_t'(0)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MOD;
        end
      end
      ST_MOD:     state_d = (bit_q == 6'd63) ? ST_P_LL : ST_MOD;
      ST_P_LL:    state_d = ST_P_RR;
      ST_P_RR:    state_d = ST_P_END;
      ST_P_END: begin
        if (pick_s < idx_t'(par_ll_q) || pick_s > gap_rr) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_B_STEP;
        end
      end
      ST_B_STEP:  state_d = more_c ? ST_B_WAIT : ST_FIN;
      ST_B_WAIT:  state_d = ST_B_STEP;
      ST_FIN:     state_d = out_free ? ST_IDLE : ST_FIN;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ecount_q    <= EntityCountRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ecount_q <= cfg_wdata_i;
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        side_q <= in_side;
        rel_q  <= in_rel;
        draw_q <= in_draw;
        res_q  <= '0;
        noc_q  <= 1'b1;
      end
      ST_RNG: begin
        first_q <= rng_first;
        last_q  <= rng_last;
        lo_q    <= rng_first - idx_t'(1);
        hi_q    <= rng_last;
      end
      ST_L_STEP: begin
        mid_q <= mid_c;
        if (!more_c) begin
          ll_q <= hi_q;
          lo_q <= first_q;
          hi_q <= last_q + idx_t'(1);
        end
      end
      ST_L_WAIT: begin
        if (rd_rel >= rel_q) hi_q <= mid_q;
        else                 lo_q <= mid_q;
      end
      ST_R_STEP: begin
        mid_q <= mid_c;
        if (!more_c) rr_q <= lo_q;
      end
      ST_R_WAIT: begin
        if (rd_rel <= rel_q) lo_q <= mid_q;
        else                 hi_q <= mid_q;
      end
      ST_CHK_RR:  ok_q <= (rd_rel == rel_q);
      ST_CHK_END: begin
        len_q <= len_c;
        div_q <= divisor_c[CountW-1:0];
        rem_q <= '0;
        bit_q <= '0;
      end
      ST_MOD: begin
        rem_q  <= rem_n[CountW-1:0];
        draw_q <= {draw_q[DrawW-2:0], 1'b0};
        bit_q  <= bit_q + 6'd1;
      end
      ST_P_RR:    par_ll_q <= rd_par;
      ST_P_END: begin
        noc_q <= 1'b0;
        if (pick_s < idx_t'(par_ll_q)) begin
          res_q <= rem_q[EntW-1:0];
        end else if (pick_s > gap_rr) begin
          res_q <= EntW'(pick_s + len_q);
        end
        lo_q <= ll_q;
        hi_q <= rr_q + idx_t'(1);
      end
      ST_B_STEP: begin
        mid_q <= mid_c;
        if (!more_c) res_q <= EntW'(pick_s + lo_q - ll_q + idx_t'(1));
      end
      ST_B_WAIT: begin
        if (gap_mid < pick_s) lo_q <= mid_q;
        else                  hi_q <= mid_q;
      end
      ST_FIN: begin
        if (out_free) begin
          out_ent_q <= res_q;
          out_noc_q <= noc_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_ent_q);
  assign m_axis_tuser  = out_noc_q;

endmodule
